@@ rtl/record_exchange_sorter_unit_assert.svh @@
// Assertion macros for the record exchange sorter.
// Included by the top level; no other dependencies.
`ifndef RECORD_EXCHANGE_SORTER_UNIT_ASSERT_SVH
`define RECORD_EXCHANGE_SORTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Condition holds in the same cycle.
`define RXS_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rxs assertion failed");
// Condition holds in the following cycle.
`define RXS_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rxs assertion failed");
`else
`define RXS_ASSERT_IMP(label, ck, rs, ante, cons)
`define RXS_ASSERT_NXT(label, ck, rs, ante, cons)
`endif
`endif

@@ rtl/rxs_pkg.sv @@
// Shared constants and types for the record exchange sorter.
// No dependencies.
package rxs_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 16;
  localparam int PAY_W  = 32;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } record_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic sort_init;
    logic fetch_i;
    logic hold_i;
    logic scan;
    logic put_i;
    logic emit_init;
    logic emit_rd;
    logic emit_next;
    logic clear_set;
  } rxs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic i_last;
    logic scan_more;
    logic k_last;
    logic empty;
  } rxs_status_t;

endpackage

@@ rtl/rxs_if.sv @@
// Valid/ready channel interfaces for records in and sorted results out.
// Depends on rxs_pkg.
interface rxs_in_if import rxs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] sort_key;
  logic [PAY_W-1:0] payload;
  logic             is_last;

  modport source (output valid, sort_key, payload, is_last, input ready);
  modport sink   (input valid, sort_key, payload, is_last, output ready);
endinterface

interface rxs_out_if import rxs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] out_key;
  logic [PAY_W-1:0] out_payload;
  logic             out_last;
  logic             overflowed;

  modport source (output valid, out_key, out_payload, out_last, overflowed, input ready);
  modport sink   (input valid, out_key, out_payload, out_last, overflowed, output ready);
endinterface

@@ rtl/rxs_ctrl.sv @@
// Controller state machine of the record exchange sorter.
// Depends on rxs_pkg.
module rxs_ctrl import rxs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_is_last,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output rxs_cmd_t    cmd,
  input  rxs_status_t status
);

  localparam logic [2:0] S_LOAD     = 3'd0;
  localparam logic [2:0] S_FETCH    = 3'd1;
  localparam logic [2:0] S_HOLD     = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_PUT      = 3'd4;
  localparam logic [2:0] S_EMIT_RD  = 3'd5;
  localparam logic [2:0] S_EMIT_OUT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_LOAD);
    out_valid  = (state == S_EMIT_OUT);
    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_is_last) begin
            cmd.sort_init = 1'b1;
            state_next    = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        // Last outer position needs no pass: start emitting.
        if (status.i_last) begin
          cmd.emit_init = 1'b1;
          state_next    = S_EMIT_RD;
        end else begin
          cmd.fetch_i = 1'b1;
          state_next  = S_HOLD;
        end
      end
      S_HOLD: begin
        cmd.hold_i = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (!status.scan_more) state_next = S_PUT;
      end
      S_PUT: begin
        cmd.put_i  = 1'b1;
        state_next = S_FETCH;
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_ready) begin
          if (status.k_last) begin
            cmd.clear_set = 1'b1;
            state_next    = S_LOAD;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = S_EMIT_RD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/rxs_datapath.sv @@
// Datapath of the record exchange sorter: record store, counters, compare-swap.
// Depends on rxs_pkg.
module rxs_datapath import rxs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  rxs_cmd_t         cmd,
  input  logic [KEY_W-1:0] in_key,
  input  logic [PAY_W-1:0] in_payload,
  output logic [KEY_W-1:0] out_key,
  output logic [PAY_W-1:0] out_payload,
  output logic             out_last,
  output logic             overflowed,
  output rxs_status_t      status
);

  record_t            mem [DEPTH];
  record_t            rd_data;
  logic [ADDR_W-1:0]  rd_tag;
  record_t            hold;
  logic [CNT_W-1:0]   fill;
  logic               overflow;
  logic [CNT_W-1:0]   i;
  logic [CNT_W-1:0]   j;
  logic [CNT_W-1:0]   k;

  logic               room;
  logic               swap;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  record_t            wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;

  assign room = (fill < CNT_W'(DEPTH));
  assign swap = (hold.key > rd_data.key);

  assign status.i_last    = (CNT_W'(i + CNT_W'(1)) >= fill);
  assign status.scan_more = (j < fill);
  assign status.k_last    = (CNT_W'(k + CNT_W'(1)) == fill);
  assign status.empty     = (fill == '0);

  // Single write port: new record, swapped-out entry, or settled minimum.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i[ADDR_W-1:0];
    wr_data = hold;
    if (cmd.load && room) begin
      wr_en   = 1'b1;
      wr_addr = fill[ADDR_W-1:0];
      wr_data = '{key: in_key, payload: in_payload};
    end else if (cmd.scan && swap) begin
      wr_en   = 1'b1;
      wr_addr = rd_tag;
    end else if (cmd.put_i) begin
      wr_en   = 1'b1;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = j[ADDR_W-1:0];
    if (cmd.fetch_i) begin
      rd_en   = 1'b1;
      rd_addr = i[ADDR_W-1:0];
    end else if (cmd.hold_i || (cmd.scan && status.scan_more)) begin
      rd_en   = 1'b1;
    end else if (cmd.emit_rd) begin
      rd_en   = 1'b1;
      rd_addr = k[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_tag  <= rd_addr;
    end
  end

  // Candidate for position i; take the smaller key on a swap.
  always_ff @(posedge clk) begin
    if (cmd.hold_i || (cmd.scan && swap)) hold <= rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      overflow <= 1'b0;
      i        <= '0;
      j        <= '0;
      k        <= '0;
    end else begin
      if (cmd.clear_set) begin
        fill     <= '0;
        overflow <= 1'b0;
      end else if (cmd.load) begin
        if (room) fill <= CNT_W'(fill + CNT_W'(1));
        else      overflow <= 1'b1;
      end
      if (cmd.sort_init)  i <= '0;
      else if (cmd.put_i) i <= CNT_W'(i + CNT_W'(1));
      if (cmd.fetch_i) begin
        j <= CNT_W'(i + CNT_W'(1));
      end else if (cmd.hold_i || (cmd.scan && status.scan_more)) begin
        j <= CNT_W'(j + CNT_W'(1));
      end
      if (cmd.emit_init)      k <= '0;
      else if (cmd.emit_next) k <= CNT_W'(k + CNT_W'(1));
    end
  end

  assign out_key     = rd_data.key;
  assign out_payload = rd_data.payload;
  assign out_last    = status.k_last;
  assign overflowed  = overflow;

endmodule

@@ rtl/record_exchange_sorter_unit.sv @@
// Record exchange sorter: collects up to DEPTH key/payload records, sorts
// them by ascending key with an exchange sort, and streams them back out.
// Depends on rxs_pkg, rxs_if, rxs_ctrl, rxs_datapath and the assertion header.
//
// Usage:
//   records: valid/ready input of sort_key, payload and is_last. Each transfer
//     stores one record while fewer than DEPTH are held; extra records are
//     dropped and flag the set as overflowed. The transfer with is_last closes
//     the set, even when that record itself is dropped.
//   results: valid/ready output of out_key, out_payload, out_last and
//     overflowed, one transfer per stored record in sorted order, out_last on
//     the final one, overflowed on every record of a set that lost records.
//   Sorting a set of n stored records: one compare-swap per cycle on a
//     single-port-read record memory, n*(n-1)/2 compares in all, plus a
//     fetch, hold and write-back step for each of the first n-1 outer
//     positions and a closing step. Output then reads each record from
//     memory and presents it, one record at a time.
//   The records channel is not ready while a set sorts or drains; it reopens
//     in the cycle after the last result transfer.
//   Reset (rst, synchronous) empties the set and returns to loading; the record
//     memory is not cleared, since only written entries are ever read.
//   A stall on results simply holds the presented record until it is taken.
module record_exchange_sorter_unit import rxs_pkg::*; (
  input  logic clk,
  input  logic rst,
  rxs_in_if.sink    records,
  rxs_out_if.source results
);

`include "record_exchange_sorter_unit_assert.svh"

  rxs_cmd_t    cmd;
  rxs_status_t status;

  // Sequencing: load, sort passes, drain.
  rxs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (records.valid),
    .in_is_last (records.is_last),
    .in_ready   (records.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .cmd        (cmd),
    .status     (status)
  );

  // Record memory, counters and the compare-swap unit.
  rxs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_key      (records.sort_key),
    .in_payload  (records.payload),
    .out_key     (results.out_key),
    .out_payload (results.out_payload),
    .out_last    (results.out_last),
    .overflowed  (results.overflowed),
    .status      (status)
  );

  // Loading and draining never overlap.
  `RXS_ASSERT_IMP(a_no_overlap, clk, rst, records.ready, !results.valid)
  // A result is only presented from a non-empty set.
  `RXS_ASSERT_IMP(a_emit_nonempty, clk, rst, results.valid, !status.empty)
  // The closing record stops loading in the next cycle.
  `RXS_ASSERT_NXT(a_last_closes, clk, rst,
    records.valid && records.ready && records.is_last, !records.ready)
  // The final result transfer reopens the records channel.
  `RXS_ASSERT_NXT(a_last_reopens, clk, rst,
    results.valid && results.ready && results.out_last, records.ready)

endmodule
